// ===== sv/plmr_pkg.sv =====
// Shared types, codes and constants for the PHY link mode resolver.
package plmr_pkg;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Result action codes
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PHY_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_GIGABIT_MAC   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // PHY register numbers
    localparam logic [4:0] MII_CONTROL   = 5'd0;
    localparam logic [4:0] MII_STATUS    = 5'd1;
    localparam logic [4:0] MII_AN_ADV    = 5'd4;
    localparam logic [4:0] MII_AN_LPA    = 5'd5;
    localparam logic [4:0] MII_GB_CTRL   = 5'd9;
    localparam logic [4:0] MII_GB_STAT   = 5'd10;

    localparam logic [15:0] CTRL_RESET_BIT  = 16'h8000;
    localparam logic [15:0] READ_ALL_ONES   = 16'hFFFF;
    localparam logic [31:0] TIMEOUT_DEFAULT = 32'd3000000;
    localparam logic [31:0] ELAPSED_MAX     = 32'hFFFF_FFFF;

    localparam int CMD_DEPTH_DEFAULT = 4;
    localparam int RES_DEPTH_DEFAULT = 4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST1,
        PH_RST2,
        PH_ANWAIT,
        PH_FALLBACK,
        PH_R9,
        PH_R10,
        PH_R4,
        PH_R5
    } phase_t;

    // Classified event handed from the front to the sequencer
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
    } evt_t;

    // One result item
    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  phy_register;
        logic [15:0] write_value;
        logic        link_failed;
        logic        gigabit;
        logic        speed_100;
        logic        full_duplex;
        logic        autonegotiated;
        logic        last_of_run;
    } res_t;

    // All results of one event: one or two
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } bundle_t;

    function automatic res_t mk_req(input logic [1:0] act, input logic [4:0] regnum,
                                    input logic [15:0] wv);
        res_t r;
        r = '0;
        r.action       = act;
        r.phy_register = regnum;
        r.write_value  = wv;
        return r;
    endfunction

    function automatic res_t mk_fin(input logic fail, input logic g, input logic s,
                                    input logic d, input logic a);
        res_t r;
        r = '0;
        r.action         = ACT_FINISH;
        r.link_failed    = fail;
        r.gigabit        = g;
        r.speed_100      = s;
        r.full_duplex    = d;
        r.autonegotiated = a;
        return r;
    endfunction

endpackage

// ===== sv/plmr_fifo.sv =====
// Small register-based FIFO used for the event and result queues.
module plmr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/plmr_front.sv =====
// Input side: classifies commands, folds invalid reads to all ones, queues events.
module plmr_front #(
    parameter int CMD_DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     command,
    input  logic [15:0]    read_value,
    input  logic           read_invalid,
    output logic           evt_valid,
    output plmr_pkg::evt_t evt,
    input  logic           evt_take
);
    import plmr_pkg::*;

    evt_t in_evt;
    logic known_cmd;
    logic evt_empty;

    // unused command code is accepted and dropped here
    assign known_cmd    = (command == CMD_START) || (command == CMD_READ) ||
                          (command == CMD_TICK);
    assign in_evt.kind  = command;
    assign in_evt.value = read_invalid ? READ_ALL_ONES : read_value;
    assign evt_valid    = !evt_empty;

    plmr_fifo #(
        .WIDTH ($bits(evt_t)),
        .DEPTH (CMD_DEPTH)
    ) u_evt_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && known_cmd),
        .push_data (in_evt),
        .full      (full),
        .pop       (evt_take),
        .pop_data  (evt),
        .empty     (evt_empty)
    );

endmodule

// ===== sv/plmr_seq.sv =====
// Bring-up sequencer: phase machine, elapsed counter and link mode resolution.
module plmr_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              gigabit_mac,
    input  logic [31:0]       timeout_ticks,
    input  logic              evt_valid,
    input  plmr_pkg::evt_t    evt,
    output logic              evt_take,
    input  logic              bundle_full,
    output logic              bundle_push,
    output plmr_pkg::bundle_t bundle
);
    import plmr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        gig_reg, gig_next;
    logic        spd_reg, spd_next;
    logic        dup_reg, dup_next;
    logic        an_reg, an_next;
    logic [15:0] saved_reg, saved_next;
    logic [15:0] v, both;
    logic        timed_out;
    logic [1:0]  n;
    res_t        r0, r1;

    assign evt_take  = evt_valid && !bundle_full;
    assign v         = evt.value;
    assign both      = saved_reg & v;
    assign timed_out = elapsed_reg > timeout_ticks;

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        gig_next     = gig_reg;
        spd_next     = spd_reg;
        dup_next     = dup_reg;
        an_next      = an_reg;
        saved_next   = saved_reg;
        r0           = '0;
        r1           = '0;
        n            = 2'd0;
        if (evt_take)
        begin
            priority if (evt.kind == CMD_START)
            begin
                elapsed_next = '0;
                gig_next     = 1'b0;
                spd_next     = 1'b0;
                dup_next     = 1'b0;
                an_next      = 1'b0;
                r0           = mk_req(ACT_READ, MII_CONTROL, '0);
                n            = 2'd1;
                phase_next   = PH_RST1;
            end
            else if (evt.kind == CMD_TICK)
            begin
                if (elapsed_reg != ELAPSED_MAX)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_RST1, PH_RST2:
                    begin
                        if (v[15])
                        begin
                            n = 2'd1;
                            if (timed_out)
                            begin
                                r0 = mk_fin(1'b1, gig_reg, spd_reg, dup_reg, an_reg);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                r0 = mk_req(ACT_READ, MII_CONTROL, '0);
                            end
                        end
                        else if (phase_reg == PH_RST1)
                        begin
                            r0 = mk_req(ACT_WRITE, MII_CONTROL, CTRL_RESET_BIT | v);
                            r1 = mk_req(ACT_READ, MII_CONTROL, '0);
                            n  = 2'd2;
                            phase_next = PH_RST2;
                        end
                        else if (!v[12])
                        begin
                            // no autoneg ability: clear control, finish 10 half
                            r0 = mk_req(ACT_WRITE, MII_CONTROL, '0);
                            r1 = mk_fin(1'b0, gig_reg, spd_reg, dup_reg, an_reg);
                            n  = 2'd2;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            an_next = 1'b1;
                            r0 = mk_req(ACT_READ, MII_STATUS, '0);
                            n  = 2'd1;
                            phase_next = PH_ANWAIT;
                        end
                    end
                    PH_ANWAIT:
                    begin
                        n = 2'd1;
                        if (!v[5])
                        begin
                            r0 = mk_req(ACT_READ, timed_out ? MII_CONTROL : MII_STATUS, '0);
                            if (timed_out)
                            begin
                                phase_next = PH_FALLBACK;
                            end
                        end
                        else if (v[8])
                        begin
                            r0 = mk_req(ACT_READ, MII_GB_CTRL, '0);
                            phase_next = PH_R9;
                        end
                        else
                        begin
                            r0 = mk_req(ACT_READ, MII_AN_ADV, '0);
                            phase_next = PH_R4;
                        end
                    end
                    PH_FALLBACK:
                    begin
                        gig_next = v[6] && !v[13];
                        spd_next = !v[6] && v[13];
                        dup_next = v[8];
                        r0 = mk_fin(1'b0, gig_next, spd_next, dup_next, an_reg);
                        n  = 2'd1;
                        phase_next = PH_IDLE;
                    end
                    PH_R9:
                    begin
                        saved_next = v;
                        r0 = mk_req(ACT_READ, MII_GB_STAT, '0);
                        n  = 2'd1;
                        phase_next = PH_R10;
                    end
                    PH_R10:
                    begin
                        if (saved_reg[9] && v[11])
                        begin
                            gig_next = 1'b1;
                            dup_next = 1'b1;
                        end
                        else if (saved_reg[8] && v[10])
                        begin
                            gig_next = 1'b1;
                            dup_next = 1'b0;
                        end
                        n = 2'd1;
                        if (!gig_next || !gigabit_mac)
                        begin
                            r0 = mk_req(ACT_READ, MII_AN_ADV, '0);
                            phase_next = PH_R4;
                        end
                        else
                        begin
                            r0 = mk_fin(1'b0, gig_next, spd_reg, dup_next, an_reg);
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_R4:
                    begin
                        saved_next = v;
                        r0 = mk_req(ACT_READ, MII_AN_LPA, '0);
                        n  = 2'd1;
                        phase_next = PH_R5;
                    end
                    PH_R5:
                    begin
                        // highest common 10/100 mode
                        priority if (both[8])
                        begin
                            spd_next = 1'b1;
                            dup_next = 1'b1;
                        end
                        else if (both[7])
                        begin
                            spd_next = 1'b1;
                            dup_next = 1'b0;
                        end
                        else if (both[6])
                        begin
                            spd_next = 1'b0;
                            dup_next = 1'b1;
                        end
                        else
                        begin
                            spd_next = 1'b0;
                            dup_next = 1'b0;
                        end
                        phase_next = PH_IDLE;
                        if (gig_reg && !gigabit_mac)
                        begin
                            // MAC cannot do gigabit: force 100/10 half
                            gig_next = 1'b0;
                            dup_next = 1'b0;
                            r0 = mk_req(ACT_WRITE, MII_CONTROL, {2'b00, spd_next, 13'd0});
                            r1 = mk_fin(1'b0, 1'b0, spd_next, 1'b0, an_reg);
                            n  = 2'd2;
                        end
                        else
                        begin
                            r0 = mk_fin(1'b0, gig_reg, spd_next, dup_next, an_reg);
                            n  = 2'd1;
                        end
                    end
                    default:
                    begin
                        // read completion while idle: ignored
                    end
                endcase
            end
        end
        r0.last_of_run = (n == 2'd1);
        r1.last_of_run = (n == 2'd2);
    end

    assign bundle_push = (n != 2'd0);
    assign bundle.two  = (n == 2'd2);
    assign bundle.r0   = r0;
    assign bundle.r1   = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            gig_reg     <= 1'b0;
            spd_reg     <= 1'b0;
            dup_reg     <= 1'b0;
            an_reg      <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            gig_reg     <= gig_next;
            spd_reg     <= spd_next;
            dup_reg     <= dup_next;
            an_reg      <= an_next;
        end
    end

    always_ff @(posedge clk)
    begin
        saved_reg <= saved_next;
    end

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        evt_take && evt.kind == CMD_START |=> phase_reg == PH_RST1 && elapsed_reg == '0)
        else $error("start did not restart bring-up");

    a_elapsed_sat: assert property (@(posedge clk) disable iff (!rst_n)
        evt_take && evt.kind == CMD_TICK && elapsed_reg == ELAPSED_MAX
        |=> elapsed_reg == ELAPSED_MAX)
        else $error("elapsed counter wrapped");

    a_finish_idles: assert property (@(posedge clk) disable iff (!rst_n)
        bundle_push && (bundle.two ? bundle.r1.action : bundle.r0.action) == ACT_FINISH
        |=> phase_reg == PH_IDLE)
        else $error("finish result without return to idle");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        bundle_push |-> !bundle_full)
        else $error("result pushed into full queue");

endmodule

// ===== sv/plmr_out.sv =====
// Output side: result bundle queue and output register that hands out one result per pop.
module plmr_out #(
    parameter int RES_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bundle_push,
    input  plmr_pkg::bundle_t bundle,
    output logic              bundle_full,
    output logic              empty,
    input  logic              pop,
    output plmr_pkg::res_t    res
);
    import plmr_pkg::*;

    bundle_t q_data;
    bundle_t cur_reg;
    logic    q_empty;
    logic    valid_reg;
    logic    idx_reg;
    logic    done;
    logic    load;

    assign done  = pop && valid_reg && (idx_reg || !cur_reg.two);
    assign load  = !q_empty && (!valid_reg || done);
    assign empty = !valid_reg;
    assign res   = idx_reg ? cur_reg.r1 : cur_reg.r0;

    plmr_fifo #(
        .WIDTH ($bits(bundle_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bundle_push),
        .push_data (bundle),
        .full      (bundle_full),
        .pop       (load),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop && valid_reg)
        begin
            idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_data;
        end
    end

endmodule

// ===== sv/phy_link_mode_resolver.sv =====
// Top level of the PHY link mode resolver: config registers, front, sequencer, output.
//
//  channel   direction  handshake        transfer when
//  -------   ---------  ---------------  -----------------------------
//  input     in         push / full      push && !full
//  result    out        empty / pop      pop && !empty
//  config    in         write_enable     write_enable (no stall)
//
//  Cycles: an event is accepted every cycle while the event queue has room; the
//  sequencer retires one event per cycle while the result queue has room; the output
//  register hands out one result per cycle while pop is held, so an event with two
//  results needs two pops. An accepted event passes through the event queue, the
//  result queue and the output register before its first result is on the ports.
//  Reset: async active low; clears phase, elapsed counter, mode bits and all queues.
//  Stalls: a full result queue holds the sequencer; that backs up the event queue and
//  raises full. Unknown command codes are accepted and dropped.
module phy_link_mode_resolver #(
    parameter int CMD_DEPTH = plmr_pkg::CMD_DEPTH_DEFAULT,
    parameter int RES_DEPTH = plmr_pkg::RES_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [15:0] read_value,
    input  logic        read_invalid,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  action,
    output logic [4:0]  phy_register,
    output logic [15:0] write_value,
    output logic        link_failed,
    output logic        gigabit,
    output logic        speed_100,
    output logic        full_duplex,
    output logic        autonegotiated,
    output logic        last_of_run,
    // configuration
    input  logic        write_enable,
    input  logic [1:0]  register_index,
    input  logic [31:0] write_data
);
    import plmr_pkg::*;

    // The PHY address register belongs to the MDIO master, which adds it to every
    // request; nothing in this block depends on it, so writes to it are accepted here
    // and not held.
    logic        gigabit_mac_reg;
    logic [31:0] timeout_ticks_reg;

    evt_t        evt;
    logic        evt_valid;
    logic        evt_take;
    bundle_t     bundle;
    logic        bundle_push;
    logic        bundle_full;
    res_t        res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gigabit_mac_reg   <= 1'b0;
            timeout_ticks_reg <= TIMEOUT_DEFAULT;
        end
        else if (write_enable)
        begin
            unique case (register_index)
                CFG_GIGABIT_MAC:   gigabit_mac_reg   <= write_data[0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= write_data;
                default:
                begin
                    // phy address and unused indexes: nothing held here
                end
            endcase
        end
    end

    // front: classify and queue events
    plmr_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .read_value   (read_value),
        .read_invalid (read_invalid),
        .evt_valid    (evt_valid),
        .evt          (evt),
        .evt_take     (evt_take)
    );

    // back: sequencer, one event per cycle while the result queue has room
    plmr_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .gigabit_mac   (gigabit_mac_reg),
        .timeout_ticks (timeout_ticks_reg),
        .evt_valid     (evt_valid),
        .evt           (evt),
        .evt_take      (evt_take),
        .bundle_full   (bundle_full),
        .bundle_push   (bundle_push),
        .bundle        (bundle)
    );

    // result queue and output register
    plmr_out #(
        .RES_DEPTH (RES_DEPTH)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .bundle_push (bundle_push),
        .bundle      (bundle),
        .bundle_full (bundle_full),
        .empty       (empty),
        .pop         (pop),
        .res         (res)
    );

    assign action         = res.action;
    assign phy_register   = res.phy_register;
    assign write_value    = res.write_value;
    assign link_failed    = res.link_failed;
    assign gigabit        = res.gigabit;
    assign speed_100      = res.speed_100;
    assign full_duplex    = res.full_duplex;
    assign autonegotiated = res.autonegotiated;
    assign last_of_run    = res.last_of_run;

endmodule
